// ===== rtl/humidity_temp_frame_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HTFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and CRC/scaling helpers for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [23:0] TEMP_OFFSET = 24'd2949075;  // 45 * 65535

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_BAD = 2'd1,
    ST_HUM_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    status_t           frame_status;
    logic [6:0]        humidity_pct;
    logic signed [8:0] temperature_c;
  } result_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^24
  function automatic logic [8:0] div_full_scale(input logic [23:0] x);
    logic [24:0] s;
    s = {1'b0, x} + {17'd0, x[23:16]} + 25'd1;
    return s[24:16];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/htfd_conv.sv =====
// ----------------------------------------------------------------------------
// htfd_conv
// Raw 16-bit word to whole degrees C and whole percent, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_conv
  import htfd_pkg::*;
(
  input  wire logic [15:0]       raw,
  output logic signed [8:0]      temperature_c,
  output logic [6:0]             humidity_pct
);

  logic [23:0] temp_scaled;
  logic [23:0] temp_diff;
  logic [8:0]  temp_mag;
  logic [23:0] hum_scaled;
  logic [8:0]  hum_q;

  always_comb begin
    temp_scaled = 24'(raw) * 24'd175;
    if (temp_scaled >= TEMP_OFFSET) begin
      temp_diff = temp_scaled - TEMP_OFFSET;
    end else begin
      temp_diff = TEMP_OFFSET - temp_scaled;
    end
    temp_mag = div_full_scale(temp_diff);
    temperature_c = (temp_scaled >= TEMP_OFFSET) ? $signed(temp_mag) : -$signed(temp_mag);

    hum_scaled   = 24'(raw) * 24'd100;
    hum_q        = div_full_scale(hum_scaled);
    humidity_pct = hum_q[6:0];
  end

endmodule

`default_nettype wire

// ===== rtl/htfd_seq.sv =====
// ----------------------------------------------------------------------------
// htfd_seq
// Byte sequencer: tracks reply position, runs CRC, holds words and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_seq
  import htfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output logic            at_last,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [2:0] {
    P_TEMP_HI  = 3'd0,
    P_TEMP_LO  = 3'd1,
    P_TEMP_CRC = 3'd2,
    P_HUM_HI   = 3'd3,
    P_HUM_LO   = 3'd4,
    P_HUM_CRC  = 3'd5
  } pos_t;

  pos_t              pos, pos_next, pos_eff;
  logic [7:0]        crc, crc_next;
  logic [7:0]        word_hi, word_hi_next;
  logic [15:0]       raw_hold, raw_hold_next;
  logic signed [8:0] temp_hold, temp_hold_next;
  logic              temp_bad, temp_bad_next;
  logic signed [8:0] conv_temp;
  logic [6:0]        conv_hum;
  status_t           status;

  htfd_conv u_conv (
    .raw           (raw_hold),
    .temperature_c (conv_temp),
    .humidity_pct  (conv_hum)
  );

  always_comb begin
    pos_eff        = frame_start ? P_TEMP_HI : pos;
    pos_next       = pos;
    crc_next       = crc;
    word_hi_next   = word_hi;
    raw_hold_next  = raw_hold;
    temp_hold_next = temp_hold;
    temp_bad_next  = temp_bad;
    res_valid      = 1'b0;

    if (temp_bad) begin
      status = ST_TEMP_BAD;
    end else if (crc != rx_byte) begin
      status = ST_HUM_BAD;
    end else begin
      status = ST_OK;
    end
    res.frame_status  = status;
    res.temperature_c = (status == ST_TEMP_BAD) ? 9'sd0 : temp_hold;
    res.humidity_pct  = (status == ST_OK) ? conv_hum : 7'd0;

    if (take) begin
      unique case (pos_eff)
        P_TEMP_HI, P_HUM_HI: begin
          crc_next     = crc8_update(CRC_INIT, rx_byte);
          word_hi_next = rx_byte;
          pos_next     = (pos_eff == P_TEMP_HI) ? P_TEMP_LO : P_HUM_LO;
        end
        P_TEMP_LO, P_HUM_LO: begin
          crc_next      = crc8_update(crc, rx_byte);
          raw_hold_next = {word_hi, rx_byte};
          pos_next      = (pos_eff == P_TEMP_LO) ? P_TEMP_CRC : P_HUM_CRC;
        end
        P_TEMP_CRC: begin
          temp_bad_next  = (crc != rx_byte);
          temp_hold_next = conv_temp;
          crc_next       = CRC_INIT;
          pos_next       = P_HUM_HI;
        end
        P_HUM_CRC: begin
          res_valid = 1'b1;
          crc_next  = CRC_INIT;
          pos_next  = P_TEMP_HI;
        end
        default: begin
          pos_next = P_TEMP_HI;
        end
      endcase
    end
  end

  assign at_last = (pos == P_HUM_CRC);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= P_TEMP_HI;
      crc       <= CRC_INIT;
      word_hi   <= 8'd0;
      raw_hold  <= 16'd0;
      temp_hold <= 9'sd0;
      temp_bad  <= 1'b0;
    end else begin
      pos       <= pos_next;
      crc       <= crc_next;
      word_hi   <= word_hi_next;
      raw_hold  <= raw_hold_next;
      temp_hold <= temp_hold_next;
      temp_bad  <= temp_bad_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_unit
// Decodes six-byte humidity/temperature sensor replies into scaled readings.
// ----------------------------------------------------------------------------
// Input stream: one reply byte per transfer, s_tdata[7:0]; s_tuser high marks
// the first byte of a reply and resynchronizes the byte position.
// Output stream: one transfer per complete reply, after its sixth byte;
// m_tdata carries temperature (signed degrees C) and humidity (percent),
// m_tuser the status (ok, temperature CRC bad, humidity CRC bad).
// Throughput: one byte per cycle. Latency: the result appears on m_tvalid the
// cycle after the sixth byte's transfer, set by the single output register.
// Reset (rst, synchronous): position returns to the first byte, CRC to 0xFF,
// output register empties.
// Receiver stall: while a result waits, bytes 1 to 5 of the next reply are
// still taken; the sixth is held off until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_unit_assert.svh"

module humidity_temp_frame_decoder_unit
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [8:0] temperature_c, [15:9] humidity_pct
  output logic [1:0]       m_tuser    // [1:0] frame_status
);

  logic    take;
  logic    at_last;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_tready = m_tready || !m_tvalid || !at_last;
  assign take     = s_tvalid && s_tready;

  htfd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .at_last     (at_last),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      m_tvalid <= res_valid;
    end
    if (m_tready || !m_tvalid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.humidity_pct, out_res.temperature_c};
  assign m_tuser = out_res.frame_status;

  `HTFD_ASSERT_NEXT(a_result_registered, res_valid, m_tvalid, "result lost")
  `HTFD_ASSERT_SAME(a_status_code,
    m_tvalid, (m_tuser == ST_OK || m_tuser == ST_TEMP_BAD || m_tuser == ST_HUM_BAD),
    "bad status code")
  `HTFD_ASSERT_SAME(a_temp_bad_zero,
    m_tvalid && m_tuser == ST_TEMP_BAD, m_tdata == 16'd0, "fields not zero on temp error")
  `HTFD_ASSERT_SAME(a_ranges,
    m_tvalid, ($signed(m_tdata[8:0]) >= -9'sd45 && $signed(m_tdata[8:0]) <= 9'sd130
               && m_tdata[15:9] <= 7'd100), "reading out of range")

endmodule

`default_nettype wire
